FILE: hw/rtl/line_from_two_points_normal_form_macros.svh
// Assertion macros for the line-from-two-points checker.
// No dependencies.
`ifndef LINE_FROM_TWO_POINTS_NORMAL_FORM_MACROS_SVH
`define LINE_FROM_TWO_POINTS_NORMAL_FORM_MACROS_SVH

// a |-> b, sampled on clk, off in reset
`define LTP_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a |=> b, sampled on clk, off in reset
`define LTP_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/ltp_pkg.sv
// Package for the line-from-two-points unit: widths and bit counts.
// No dependencies.
package ltp_pkg;
  localparam int CW = 32;            // coordinate width
  localparam int DW = CW + 1;        // difference width
  localparam int NW = 32;            // normal width (Q2.30)
  localparam int MW = 31;            // min_distance width
  localparam int QB = 31;            // quotient bits
  localparam int SB = 32;            // sqrt result bits
endpackage

FILE: hw/rtl/line_from_two_points_normal_form.sv
// Line through two points, Hessian normal form, fully pipelined.
// Depends on ltp_pkg.
//
// channel | dir | payload
// s_axis  | in  | tdata: first_x, first_y, second_x, second_y (32b each)
// m_axis  | out | tdata: normal_x, normal_y, offset (32b each), valid_res
// cfg     | in  | cfg_we/cfg_wdata: min_distance (31b)
//
// One item per cycle while the output is not stalled.
// The pipeline length is set by the bit-serial square root and the
// restoring divider, one bit per stage each.
// rst clears all valid bits and sets min_distance to 1.
// A stalled output freezes the whole pipeline; nothing is lost.
module line_from_two_points_normal_form
  import ltp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [30:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // first_x, first_y, second_x, second_y
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata   // normal_x, normal_y, offset, valid_res
);
  localparam int NS = SB;   // sqrt stages
  localparam int ND = QB + 1; // divider stages

  typedef struct packed {
    logic              ok;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic              sx;  // dy > 0
    logic              sy;  // dx < 0
  } side_t;

  logic [MW-1:0] min_distance;
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) min_distance <= MW'(1);
    else if (cfg_we) min_distance <= cfg_wdata;
  end

  // stage 1: differences
  logic v1;
  side_t sd1;
  logic [DW-1:0] a1, b1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_axis_tvalid;
  end
  always_ff @(posedge clk) begin
    logic signed [DW-1:0] dx, dy;
    if (adv) begin
      dx = DW'($signed(s_axis_tdata[95:64])) - DW'($signed(s_axis_tdata[31:0]));
      dy = DW'($signed(s_axis_tdata[127:96])) - DW'($signed(s_axis_tdata[63:32]));
      a1 <= dx[DW-1] ? DW'(-dx) : dx;
      b1 <= dy[DW-1] ? DW'(-dy) : dy;
      sd1.x1 <= s_axis_tdata[31:0];
      sd1.y1 <= s_axis_tdata[63:32];
      sd1.sx <= !dy[DW-1] && (dy != '0);
      sd1.sy <= dx[DW-1];
      sd1.ok <= 1'b0;
    end
  end

  // stage 2: validity, normalization
  logic v2;
  side_t sd2;
  logic [31:0] a2, b2;
  logic [DW-1:0] m1;
  logic [5:0] lz;
  assign m1 = (a1 > b1) ? a1 : b1;
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 31; i++) if (m1[i]) lz = 6'(30 - i);
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    logic [65:0] sq, mm;
    logic [31:0] na, nb;
    side_t nsd;
    if (adv) begin
      sq = 66'(a1) * 66'(a1) + 66'(b1) * 66'(b1);
      mm = 66'(min_distance) * 66'(min_distance);
      if (m1[32]) begin
        na = {1'b0, a1[32:2]}; nb = {1'b0, b1[32:2]};
      end else if (m1[31]) begin
        na = a1[32:1]; nb = b1[32:1];
      end else begin
        na = a1[31:0] << lz; nb = b1[31:0] << lz;
      end
      nsd = sd1;
      nsd.ok = (m1 != '0) && ((m1 >= DW'(33'h80000000)) || (sq >= mm));
      a2 <= na;
      b2 <= nb;
      sd2 <= nsd;
    end
  end

  // stage 3: square of the normalized length
  logic v3;
  side_t sd3;
  logic [31:0] a3, b3;
  logic [63:0] s3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3 <= 64'(a2) * 64'(a2) + 64'(b2) * 64'(b2);
      a3 <= a2;
      b3 <= b2;
      sd3 <= sd2;
    end
  end

  // bit-serial square root, one result bit per stage
  logic [NS:0] vq;
  side_t sq_sd [NS+1];
  logic [31:0] sq_a [NS+1], sq_b [NS+1];
  logic [63:0] sq_rem [NS+1];
  logic [SB-1:0] sq_r [NS+1];
  always_comb begin
    vq[0] = v3; sq_sd[0] = sd3; sq_a[0] = a3; sq_b[0] = b3;
    sq_rem[0] = s3; sq_r[0] = '0;
  end
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam int BIT = NS - 1 - k;
    always_ff @(posedge clk) begin
      if (rst) vq[k+1] <= 1'b0;
      else if (adv) vq[k+1] <= vq[k];
    end
    always_ff @(posedge clk) begin
      logic [63:0] trial;
      if (adv) begin
        trial = (64'(sq_r[k]) << (BIT + 1)) + (64'd1 << (2 * BIT));
        if (sq_rem[k] >= trial) begin
          sq_rem[k+1] <= sq_rem[k] - trial;
          sq_r[k+1] <= sq_r[k] | (SB'(1) << BIT);
        end else begin
          sq_rem[k+1] <= sq_rem[k];
          sq_r[k+1] <= sq_r[k];
        end
        sq_sd[k+1] <= sq_sd[k];
        sq_a[k+1] <= sq_a[k];
        sq_b[k+1] <= sq_b[k];
      end
    end
  end

  // restoring divider for both components, one quotient bit per stage
  logic [ND:0] vd;
  side_t dv_sd [ND+1];
  logic [63:0] ra [ND+1], rb [ND+1];
  logic [QB-1:0] qa [ND+1], qb [ND+1];
  logic [31:0] dl [ND+1];
  always_comb begin
    vd[0] = vq[NS]; dv_sd[0] = sq_sd[NS];
    dl[0] = sq_r[NS];
    ra[0] = (64'(sq_a[NS]) << 30) + 64'(sq_r[NS] >> 1);
    rb[0] = (64'(sq_b[NS]) << 30) + 64'(sq_r[NS] >> 1);
    qa[0] = '0; qb[0] = '0;
  end
  for (genvar k = 0; k < ND; k++) begin : g_div
    localparam int BIT = ND - 1 - k;
    always_ff @(posedge clk) begin
      if (rst) vd[k+1] <= 1'b0;
      else if (adv) vd[k+1] <= vd[k];
    end
    always_ff @(posedge clk) begin
      logic [95:0] t;
      if (adv) begin
        t = 96'(dl[k]) << BIT;
        if (96'(ra[k]) >= t) begin
          ra[k+1] <= ra[k] - t[63:0];
          qa[k+1] <= qa[k] | QB'(64'd1 << BIT);
        end else begin
          ra[k+1] <= ra[k];
          qa[k+1] <= qa[k];
        end
        if (96'(rb[k]) >= t) begin
          rb[k+1] <= rb[k] - t[63:0];
          qb[k+1] <= qb[k] | QB'(64'd1 << BIT);
        end else begin
          rb[k+1] <= rb[k];
          qb[k+1] <= qb[k];
        end
        dv_sd[k+1] <= dv_sd[k];
        dl[k+1] <= dl[k];
      end
    end
  end

  // stage A: signs
  logic va, vb, vc;
  side_t sa, sb;
  logic signed [NW-1:0] nxa, nya, nxb, nyb;
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0;
    end else if (adv) begin
      va <= vd[ND]; vb <= va; vc <= vb;
    end
  end
  always_ff @(posedge clk) begin
    logic signed [NW-1:0] pa, pb;
    if (adv) begin
      pa = NW'({1'b0, qa[ND]});
      pb = NW'({1'b0, qb[ND]});
      nxa <= dv_sd[ND].sx ? -pb : pb;
      nya <= dv_sd[ND].sy ? -pa : pa;
      sa <= dv_sd[ND];
    end
  end

  // stage B: products
  logic signed [95:0] dot;
  always_ff @(posedge clk) begin
    if (adv) begin
      dot <= 96'(nxa) * 96'(sa.x1) + 96'(nya) * 96'(sa.y1) + 96'(64'd1 << 29);
      nxb <= nxa; nyb <= nya; sb <= sa;
    end
  end

  // stage C: shift, saturate, gate
  logic signed [65:0] off_w;
  assign off_w = 66'(dot >>> 30);
  always_ff @(posedge clk) begin
    logic signed [CW-1:0] off;
    if (adv) begin
      if (off_w > 66'sh7FFFFFFF) off = 32'sh7FFFFFFF;
      else if (off_w < -66'sh80000000) off = 32'sh80000000;
      else off = off_w[CW-1:0];
      if (sb.ok) m_axis_tdata <= {7'd0, 1'b1, off, nyb, nxb};
      else m_axis_tdata <= '0;
    end
  end
  assign m_axis_tvalid = vc;
endmodule

FILE: hw/rtl/ltp_checker.sv
// Port-level checker for line_from_two_points_normal_form, with its bind.
// Depends on line_from_two_points_normal_form_macros.svh.
`include "line_from_two_points_normal_form_macros.svh"
module ltp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);
  `LTP_ASSERT_IMP(a_ready, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `LTP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `LTP_ASSERT_IMP(a_zero, m_axis_tvalid && !m_axis_tdata[96], m_axis_tdata[95:0] == 96'd0)
  `LTP_ASSERT_IMP(a_pad, m_axis_tvalid, m_axis_tdata[103:97] == 7'd0)
endmodule

bind line_from_two_points_normal_form ltp_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
